// ===== hdl/mip_chain_storage_accumulator_top_defines.svh =====
// Assertion macros for the mip chain storage accumulator.
// Included by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef MIP_CHAIN_STORAGE_ACCUMULATOR_TOP_DEFINES_SVH
`define MIP_CHAIN_STORAGE_ACCUMULATOR_TOP_DEFINES_SVH

// Check that is masked while reset is high.
`define MCSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds across reset.
`define MCSA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mcsa_pkg.sv =====
// Package for the mip chain storage accumulator: widths, word layout and
// sequencer states. No dependencies.
package mcsa_pkg;

  localparam int SIDE_BITS  = 16;
  localparam int LAYER_BITS = 16;

  // Input word fields
  localparam int SIDE_W  = 16;
  localparam int LAYER_W = 16;
  localparam int VIEW_W  = 16;
  localparam int PIX_W   = 5;
  localparam int IN_W    = 72;

  // Output word fields
  localparam int EB_W    = 51;
  localparam int TB_W    = 64;
  localparam int CNT_W   = 32;
  localparam int OUT_W   = 184;

  // Shared multiplier: side, texel sum, viewport width or area on A; side,
  // layers, height or pixel size on B
  localparam int TEX_W   = 2 * SIDE_BITS + 1;
  localparam int MUL_A_W = (TEX_W > 2 * VIEW_W) ? TEX_W : 2 * VIEW_W;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int BYTES_PER_TEXEL_SHIFT = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_ADD,
    ST_SCALE,
    ST_VIEW1,
    ST_VIEW2,
    ST_FINISH
  } state_t;

endpackage

// ===== hdl/mip_chain_storage_accumulator_top.sv =====
// Mip chain storage accumulator: sizes texture array and viewport allocations
// and keeps running totals. Depends on mcsa_pkg and the _defines.svh macros.
//
//  channel | dir | handshake         | payload
//  s       | in  | s_tvalid/s_tready | s_tuser = action, s_tdata = array/viewport fields
//  m       | out | m_tvalid/m_tready | m_tdata = event size and totals
//
// Steps: an array event does LEVEL and ADD once per level (L = 1+floor(log2 side),
// at most 16; 1 without mips), then SCALE and FINISH; a viewport event does VIEW1,
// VIEW2 and FINISH. The single shared multiplier gives one product per cycle.
// rst is synchronous and clears the sequencer, output valid and all totals.
// A result waiting on m_tready holds the sequencer in its last step; the next
// item is taken while that result still waits.
`include "mip_chain_storage_accumulator_top_defines.svh"

module mip_chain_storage_accumulator_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [15:0] side_length, [31:16] layers, [32] with_mips, [48:33] view_width,
  // [64:49] view_height, [69:65] pixel_bytes, [71:70] zero
  input  logic [mcsa_pkg::IN_W-1:0] s_tdata,
  // [0] action
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [50:0] event_bytes, [114:51] total_bytes, [146:115] total_events,
  // [178:147] total_layers, [183:179] zero
  output logic [mcsa_pkg::OUT_W-1:0] m_tdata
);
  import mcsa_pkg::*;

  state_t state, state_next;

  logic [SIDE_BITS-1:0] d;
  logic [TEX_W-1:0]     texels;
  logic [MUL_B_W-1:0]   cnt;
  logic                 mips;
  logic                 is_view;
  logic [VIEW_W-1:0]    w;
  logic [VIEW_W-1:0]    h;
  logic [PIX_W-1:0]     pb;
  logic [PROD_W-1:0]    prod;

  logic [TB_W-1:0]      byte_sum;
  logic [CNT_W-1:0]     event_count;
  logic [CNT_W-1:0]     layer_sum;

  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    mul_p;

  logic                 accept;
  logic                 ld_out;
  logic                 more_levels;
  logic [63:0]          prod_ext;
  logic [EB_W-1:0]      bytes;
  logic [TB_W-1:0]      byte_sum_next;
  logic [CNT_W-1:0]     event_count_next;
  logic [CNT_W-1:0]     layer_sum_next;

  assign accept      = s_tvalid && s_tready;
  assign more_levels = mips && ((d >> 1) != '0);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_LEVEL: begin
        mul_a = MUL_A_W'(d);
        mul_b = MUL_B_W'(d);
      end
      ST_SCALE: begin
        mul_a = MUL_A_W'(texels);
        mul_b = cnt;
      end
      ST_VIEW1: begin
        mul_a = MUL_A_W'(w);
        mul_b = MUL_B_W'(h);
      end
      ST_VIEW2: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(pb);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Event size and new totals
  always_comb begin
    prod_ext = is_view ? 64'(prod) : (64'(prod) << BYTES_PER_TEXEL_SHIFT);
    bytes    = prod_ext[EB_W-1:0];
    byte_sum_next    = byte_sum + TB_W'(bytes);
    event_count_next = event_count + CNT_W'(1);
    layer_sum_next   = is_view ? layer_sum : (layer_sum + CNT_W'(cnt));
  end

  // Sequencer
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ld_out     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = s_tuser ? ST_VIEW1 : ST_LEVEL;
        end
      end
      ST_LEVEL: state_next = ST_ADD;
      ST_ADD:   state_next = more_levels ? ST_LEVEL : ST_SCALE;
      ST_SCALE: state_next = ST_FINISH;
      ST_VIEW1: state_next = ST_VIEW2;
      ST_VIEW2: state_next = ST_FINISH;
      ST_FINISH: begin
        // hold while the previous result is still unclaimed
        if (!m_tvalid || m_tready) begin
          ld_out     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      d       <= s_tdata[SIDE_BITS-1:0];
      cnt     <= MUL_B_W'(s_tdata[SIDE_W +: LAYER_BITS]);
      mips    <= s_tdata[SIDE_W + LAYER_W];
      w       <= s_tdata[SIDE_W + LAYER_W + 1 +: VIEW_W];
      h       <= s_tdata[SIDE_W + LAYER_W + 1 + VIEW_W +: VIEW_W];
      pb      <= s_tdata[SIDE_W + LAYER_W + 1 + 2 * VIEW_W +: PIX_W];
      is_view <= s_tuser;
      texels  <= '0;
    end
    if (state == ST_LEVEL || state == ST_SCALE || state == ST_VIEW1 ||
        state == ST_VIEW2) begin
      prod <= mul_p;
    end
    if (state == ST_ADD) begin
      texels <= texels + prod[TEX_W-1:0];
      d      <= d >> 1;
    end
  end

  // Totals and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_sum    <= '0;
      event_count <= '0;
      layer_sum   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (ld_out) begin
        byte_sum    <= byte_sum_next;
        event_count <= event_count_next;
        layer_sum   <= layer_sum_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      m_tdata <= {5'b0, layer_sum_next, event_count_next, byte_sum_next, bytes};
    end
  end

  `MCSA_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready,
    "item accepted but block still ready")
  `MCSA_ASSERT(a_count_step, ld_out |=> (m_tvalid &&
    event_count == CNT_W'($past(event_count) + CNT_W'(1))),
    "event count did not advance by one on result load")
  `MCSA_ASSERT(a_zero_layers, (state == ST_SCALE && cnt == '0) |=> prod == '0,
    "array event with no layers gave nonzero product")
  `MCSA_ASSERT_RST(a_reset_clear, $past(rst) |-> (event_count == '0 &&
    byte_sum == '0 && layer_sum == '0 && !m_tvalid),
    "totals not cleared by reset")

endmodule

// ===== tb/mip_chain_storage_accumulator_top_tb.sv =====
// Self-checking bench for mip_chain_storage_accumulator_top: random and directed
// allocation events against a behavioral size predictor. Depends on mcsa_pkg.
module mip_chain_storage_accumulator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcsa_pkg::*;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  localparam bit ACT_ARRAY = 1'b0;
  localparam bit ACT_VIEW  = 1'b1;

  typedef struct {
    logic [EB_W-1:0]  event_bytes;
    logic [TB_W-1:0]  total_bytes;
    logic [CNT_W-1:0] total_events;
    logic [CNT_W-1:0] total_layers;
  } alloc_result_t;

  class alloc_ledger;
    alloc_result_t    expected_totals[$];
    logic [TB_W-1:0]  bytes_acc;
    logic [CNT_W-1:0] events_acc;
    logic [CNT_W-1:0] layers_acc;
    int               mismatches;

    function new();
      bytes_acc  = '0;
      events_acc = '0;
      layers_acc = '0;
      mismatches = 0;
    endfunction

    // Texels over the mip chain (or the base level only), times layers, 4 bytes each.
    function logic [63:0] array_event_bytes(logic [SIDE_W-1:0] side,
                                            logic [LAYER_W-1:0] count, bit mips);
      logic [63:0]       texels;
      logic [63:0]       lvl_side;
      logic [SIDE_W-1:0] d;
      int                levels;
      texels = '0;
      levels = 1;
      if (side == 0 || count == 0) return '0;
      if (mips) begin
        for (d = side; d > 1; d = d >> 1) levels++;
      end
      for (int lvl = 0; lvl < levels; lvl++) begin
        lvl_side = 64'(side) >> lvl;
        if (lvl_side == 0) lvl_side = 1;
        texels += lvl_side * lvl_side;
      end
      return texels * 64'(count) * 64'd4;
    endfunction

    function void note_event(bit action, logic [SIDE_W-1:0] side,
                             logic [LAYER_W-1:0] count, bit mips,
                             logic [VIEW_W-1:0] w, logic [VIEW_W-1:0] h,
                             logic [PIX_W-1:0] pix);
      logic [63:0]   bytes;
      alloc_result_t r;
      if (action == ACT_ARRAY) begin
        bytes      = array_event_bytes(side, count, mips);
        layers_acc = layers_acc + CNT_W'(count);
      end else begin
        bytes = 64'(w) * 64'(h) * 64'(pix);
      end
      bytes_acc  = bytes_acc + bytes;
      events_acc = events_acc + 1;
      r.event_bytes  = bytes[EB_W-1:0];
      r.total_bytes  = bytes_acc;
      r.total_events = events_acc;
      r.total_layers = layers_acc;
      expected_totals.push_back(r);
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_result(logic [OUT_W-1:0] word);
      alloc_result_t want;
      logic [EB_W-1:0]  got_bytes;
      logic [TB_W-1:0]  got_total;
      logic [CNT_W-1:0] got_events;
      logic [CNT_W-1:0] got_layers;
      got_bytes  = word[EB_W-1:0];
      got_total  = word[EB_W+TB_W-1:EB_W];
      got_events = word[EB_W+TB_W+CNT_W-1:EB_W+TB_W];
      got_layers = word[EB_W+TB_W+2*CNT_W-1:EB_W+TB_W+CNT_W];
      if (expected_totals.size() == 0) begin
        flag_mismatch("result word with no event pending");
        return;
      end
      want = expected_totals.pop_front();
      if (got_bytes !== want.event_bytes)
        flag_mismatch($sformatf("event_bytes got %0d want %0d", got_bytes, want.event_bytes));
      if (got_total !== want.total_bytes)
        flag_mismatch($sformatf("total_bytes got %0d want %0d", got_total, want.total_bytes));
      if (got_events !== want.total_events)
        flag_mismatch($sformatf("total_events got %0d want %0d",
                                got_events, want.total_events));
      if (got_layers !== want.total_layers)
        flag_mismatch($sformatf("total_layers got %0d want %0d",
                                got_layers, want.total_layers));
    endtask

    function int pending();
      return expected_totals.size();
    endfunction
  endclass

  alloc_ledger ledger;
  bit          send_calm;

  mip_chain_storage_accumulator_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(21, 60);
  endfunction

  task automatic send_event(bit action, logic [SIDE_W-1:0] side,
                            logic [LAYER_W-1:0] count, bit mips,
                            logic [VIEW_W-1:0] w, logic [VIEW_W-1:0] h,
                            logic [PIX_W-1:0] pix);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {2'b00, pix, h, w, mips, count, side};
    do @(posedge clk); while (!s_tready);
    ledger.note_event(action, side, count, mips, w, h, pix);
    gap = send_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_array(logic [SIDE_W-1:0] side, logic [LAYER_W-1:0] count, bit mips);
    send_event(ACT_ARRAY, side, count, mips, VIEW_W'($urandom), VIEW_W'($urandom),
               PIX_W'($urandom));
  endtask

  task automatic send_view(logic [VIEW_W-1:0] w, logic [VIEW_W-1:0] h, logic [PIX_W-1:0] pix);
    send_event(ACT_VIEW, SIDE_W'($urandom), LAYER_W'($urandom), 1'($urandom), w, h, pix);
  endtask

  function automatic logic [15:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom_range(0, 2));
    if (r < 45) return 16'($urandom_range(0, 300));
    if (r < 55) return 16'(1 << $urandom_range(0, 15));
    if (r < 62) return 16'((1 << $urandom_range(1, 16)) - 1);
    return 16'($urandom_range(0, 65535));
  endfunction

  // Result side: random stalls, calm stretches, and two long hold-offs that back
  // the block up into its input.
  initial begin
    int  stall_left;
    int  results_seen;
    int  r;
    bit  recv_calm;
    stall_left   = 0;
    results_seen = 0;
    recv_calm    = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        ledger.check_result(m_tdata);
        results_seen++;
        if (results_seen % 80 == 0) recv_calm = $urandom_range(0, 2) == 0;
        if (results_seen == 120 || results_seen == 520) stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!recv_calm && $urandom_range(0, 99) < 30) begin
        r = $urandom_range(0, 99);
        stall_left = (r < 85) ? $urandom_range(0, 4) : $urandom_range(5, 60);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int guard;
    ledger    = new();
    send_calm = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= 1'b0;
    s_tdata  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero side or zero layers still counts the event and its layers
    send_array(16'd0, 16'd5, 1'b1);
    send_array(16'd7, 16'd0, 1'b1);
    send_array(16'd0, 16'd0, 1'b0);
    send_array(16'd1, 16'd1, 1'b1);
    send_array(16'hFFFF, 16'hFFFF, 1'b1);
    send_array(16'hFFFF, 16'hFFFF, 1'b0);
    send_array(16'd1024, 16'd3, 1'b1);
    send_array(16'd1000, 16'd2, 1'b1);
    send_array(16'd2, 16'd1, 1'b0);
    send_array(16'h8000, 16'd1, 1'b1);
    // ignored viewport fields all ones on an array event, and the reverse
    send_event(ACT_ARRAY, 16'd3, 16'd2, 1'b1, 16'hFFFF, 16'hFFFF, 5'h1F);
    send_event(ACT_VIEW, 16'hFFFF, 16'hFFFF, 1'b1, 16'd640, 16'd480, 5'd4);
    send_view(16'hFFFF, 16'hFFFF, 5'h1F);
    send_view(16'd0, 16'd100, 5'd4);
    send_view(16'd1920, 16'd1080, 5'd16);
    send_view(16'd100, 16'd100, 5'd0);
    send_view(16'd1, 16'd1, 5'd1);

    for (int i = 0; i < 900; i++) begin
      if (i % 64 == 0) send_calm = $urandom_range(0, 3) == 0;
      if ($urandom_range(0, 1) == ACT_ARRAY)
        send_array(pick_dim(), ($urandom_range(0, 3) == 0) ? pick_dim()
                                                           : 16'($urandom_range(0, 16)),
                   1'($urandom));
      else
        send_view(pick_dim(), pick_dim(), PIX_W'($urandom_range(0, 31)));
    end
    s_tvalid <= 1'b0;

    guard = 0;
    while (ledger.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    if (ledger.pending() != 0)
      ledger.flag_mismatch($sformatf("%0d expected results never arrived", ledger.pending()));
    if (ledger.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mcsa_pkg.sv
hdl/mip_chain_storage_accumulator_top.sv
tb/mip_chain_storage_accumulator_top_tb.sv
